### src/lpbd_pkg.sv
// Package for the page buffer directory: payload structs, chain link and
// control types shared by the cell row and the top level.
// No dependencies.
package lpbd_pkg;

   // Fixed field widths of the request and response items.
   localparam int TABLE_W = 4;
   localparam int PAGE_W  = 20;
   localparam int SLOT_W  = 4;
   localparam int CAP_W   = 5;

   // Operation codes.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // One request item.
   typedef struct packed {
      logic              operation;
      logic [TABLE_W-1:0] table_no;
      logic [PAGE_W-1:0]  page_no;
   } req_type;

   // One response item.
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0]  slot;
      logic              evicted;
      logic [TABLE_W-1:0] evict_table;
      logic [PAGE_W-1:0]  evict_page;
      logic              writeback;
   } rsp_type;

   // Data handed from one cell to the next along the row.
   typedef struct packed {
      logic              hit_seen;
      logic              free_seen;
      logic [TABLE_W-1:0] vic_table;
      logic [PAGE_W-1:0]  vic_page;
      logic              vic_dirty;
   } link_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic capture;
      logic commit;
      logic evict;
      logic miss;
      logic write;
   } cmd_type;

endpackage

### src/lpbd_cell.sv
// One directory entry: tag, dirty bit and recency rank, with its piece of
// the hit, free-slot and victim chains. Depends on lpbd_pkg.
module lpbd_cell
   import lpbd_pkg::*;
#(
   parameter int SLOTS = 16,
   parameter int IDX   = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  req_type                    cmp_req,
   input  req_type                    load_req,
   input  logic [$clog2(SLOTS)-1:0]   victim_rank,
   input  logic [$clog2(SLOTS)-1:0]   hit_rank,
   input  link_type                   link_in,
   output link_type                   link_out,
   input  logic [$clog2(SLOTS)-1:0]   rank_acc_in,
   output logic [$clog2(SLOTS)-1:0]   rank_acc_out,
   input  logic [$clog2(SLOTS)-1:0]   hit_idx_in,
   output logic [$clog2(SLOTS)-1:0]   hit_idx_out,
   input  logic [$clog2(SLOTS)-1:0]   free_idx_in,
   output logic [$clog2(SLOTS)-1:0]   free_idx_out
);

   localparam int RW = $clog2(SLOTS);
   localparam logic [RW-1:0] MY_IDX = RW'(IDX);

   logic               valid_ff, valid_in;
   logic               dirty_ff, dirty_in;
   logic [RW-1:0]      rank_ff, rank_in;
   logic [TABLE_W-1:0] table_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic               match_ff, match_in;
   logic               victim_ff, victim_in;
   logic               free_cond;
   logic               take_free;
   logic               is_victim;

   // Tag compare and victim check against the state as it stands at accept.
   assign match_in  = valid_ff && (table_ff == cmp_req.table_no)
                      && (page_ff == cmp_req.page_no);
   assign victim_in = valid_ff && (rank_ff == victim_rank);

   // This entry is the one to evict when the pool is full.
   assign is_victim = cmd.evict && victim_ff;

   // Lowest free entry wins, counting the entry that is evicted.
   assign free_cond = !valid_ff || is_victim;
   assign take_free = free_cond && !link_in.free_seen;

   // Hand the accumulated results to the next cell.
   always_comb begin
      link_out.hit_seen  = link_in.hit_seen || match_ff;
      link_out.free_seen = link_in.free_seen || free_cond;
      link_out.vic_table = link_in.vic_table | (is_victim ? table_ff : '0);
      link_out.vic_page  = link_in.vic_page | (is_victim ? page_ff : '0);
      link_out.vic_dirty = link_in.vic_dirty | (is_victim && dirty_ff);
      rank_acc_out       = rank_acc_in | (match_ff ? rank_ff : '0);
      hit_idx_out        = hit_idx_in | (match_ff ? MY_IDX : '0);
      free_idx_out       = free_idx_in | (take_free ? MY_IDX : '0);
   end

   // Next entry state when the item commits.
   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      rank_in  = rank_ff;
      if (cmd.commit) begin
         if (cmd.miss) begin
            if (take_free) begin
               valid_in = 1'b1;
               dirty_in = cmd.write;
               rank_in  = '0;
            end else if (is_victim) begin
               valid_in = 1'b0;
               dirty_in = 1'b0;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + RW'(1);
            end
         end else if (cmd.write) begin
            if (match_ff) begin
               dirty_in = 1'b1;
               rank_in  = '0;
            end else if (valid_ff && (rank_ff < hit_rank)) begin
               rank_in = rank_ff + RW'(1);
            end
         end
      end
   end

   // Control state of the entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         dirty_ff  <= 1'b0;
         rank_ff   <= '0;
         match_ff  <= 1'b0;
         victim_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         rank_ff  <= rank_in;
         if (cmd.capture) begin
            match_ff  <= match_in;
            victim_ff <= victim_in;
         end
      end
   end

   // Tag storage, loaded when this entry takes a new page.
   always_ff @(posedge clock) begin
      if (cmd.commit && cmd.miss && take_free) begin
         table_ff <= load_req.table_no;
         page_ff  <= load_req.page_no;
      end
   end

endmodule

### src/lru_page_buffer_directory.sv
// Top level of the page buffer directory: command sequencer, capacity
// register and the row of directory cells. Depends on lpbd_pkg, lpbd_cell.
//
// Usage. A request item (read or write of one page, named by table and
// page number) is taken at a clock edge where start is high and busy is
// low. Busy stays high for the one lookup cycle that follows. At the
// end of that cycle the directory is updated and the response item
// appears on rsp_data with rsp_strobe high for exactly one cycle; the
// receiver cannot stall it, so it must take the item then.
// The tag is compared in every cell as the item is taken and the result
// registered; in the lookup cycle the hit, free-slot and victim chains
// ripple along the row of cells and the entries update. A new item is
// taken only once the lookup of the one before it is over.
// Capacity register writes use csr_write_en and csr_write_data; the user
// must make them only while no item is in flight, the block does not
// enforce it. Zero acts as one, values above SLOTS act as SLOTS.
// Synchronous reset empties the directory (no valid entries, count zero)
// and sets the capacity to 16. No clearing pass is needed.
module lru_page_buffer_directory
   import lpbd_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_write_en,
   input  logic [CAP_W-1:0]   csr_write_data
);

   localparam int RW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [EW-1:0] SLOTS_E = EW'(SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOOK = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CAP_W-1:0] capacity_ff;
   logic [CW-1:0]    used_ff, used_in;
   logic             evict_ff;
   req_type          req_ff;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic [EW-1:0]    cap_ext;
   logic [EW-1:0]    eff_cap;
   logic             evict_in;
   logic [RW-1:0]    victim_rank;
   logic             miss;
   cmd_type          cmd;

   link_type         link     [SLOTS+1];
   logic [RW-1:0]    rank_acc [SLOTS+1];
   logic [RW-1:0]    hit_idx  [SLOTS+1];
   logic [RW-1:0]    free_idx [SLOTS+1];

   assign busy   = (state_ff == ST_LOOK);
   assign accept = start && !busy;

   // Effective capacity: zero counts as one, saturate at the entry count.
   always_comb begin
      cap_ext = EW'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = EW'(1);
      end else if (cap_ext > SLOTS_E) begin
         eff_cap = SLOTS_E;
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign evict_in    = (EW'(used_ff) >= eff_cap);
   assign victim_rank = RW'(used_ff - CW'(1));

   // The hit decision comes from the end of the chain.
   assign miss = !link[SLOTS].hit_seen;

   // Broadcast control to the cells.
   always_comb begin
      cmd.capture = accept;
      cmd.commit  = (state_ff == ST_LOOK);
      cmd.evict   = evict_ff;
      cmd.miss    = miss;
      cmd.write   = (req_ff.operation == OP_WRITE);
   end

   // Chain heads.
   assign link[0]     = '0;
   assign rank_acc[0] = '0;
   assign hit_idx[0]  = '0;
   assign free_idx[0] = '0;

   // Row of directory cells.
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      lpbd_cell #(
         .SLOTS (SLOTS),
         .IDX   (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .cmp_req      (req_data),
         .load_req     (req_ff),
         .victim_rank  (victim_rank),
         .hit_rank     (rank_acc[SLOTS]),
         .link_in      (link[g]),
         .link_out     (link[g+1]),
         .rank_acc_in  (rank_acc[g]),
         .rank_acc_out (rank_acc[g+1]),
         .hit_idx_in   (hit_idx[g]),
         .hit_idx_out  (hit_idx[g+1]),
         .free_idx_in  (free_idx[g]),
         .free_idx_out (free_idx[g+1])
      );
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Entry count: a miss without eviction adds one entry.
   always_comb begin
      used_in = used_ff;
      if (cmd.commit && miss && !evict_ff) begin
         used_in = used_ff + CW'(1);
      end
   end

   // Response item assembled from the chain ends.
   always_comb begin
      rsp_in.hit         = !miss;
      rsp_in.slot        = miss ? SLOT_W'(free_idx[SLOTS]) : SLOT_W'(hit_idx[SLOTS]);
      rsp_in.evicted     = miss && evict_ff;
      rsp_in.evict_table = rsp_in.evicted ? link[SLOTS].vic_table : '0;
      rsp_in.evict_page  = rsp_in.evicted ? link[SLOTS].vic_page : '0;
      rsp_in.writeback   = rsp_in.evicted && link[SLOTS].vic_dirty;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         capacity_ff   <= CAP_RESET;
         used_ff       <= '0;
         evict_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= cmd.commit;
         if (csr_write_en) begin
            capacity_ff <= csr_write_data;
         end
         if (accept) begin
            evict_ff <= evict_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // An accepted item always holds the block for its lookup cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("lookup cycle missing after accept");

   // Every lookup cycle yields exactly one response in the next cycle.
   a_look_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |=> (rsp_strobe && !busy))
      else $error("response not issued after lookup");

   // The entry count never exceeds the number of entries.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      EW'(used_ff) <= SLOTS_E)
      else $error("entry count overflow");

   // A hit never evicts an entry.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.hit) |-> (!rsp_data.evicted && !rsp_data.writeback))
      else $error("eviction reported on a hit");

   // A miss always finds a free entry or, with a full pool, a victim entry.
   a_victim_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && miss) |-> link[SLOTS].free_seen)
      else $error("no entry available for a miss");

endmodule
